@@ sv/uef_pkg.sv @@
// Shared types and constants for the ultrasonic echo median filter.
// No dependencies; every other file of the block imports this package.
package uef_pkg;

	localparam int MM_W        = 16;
	localparam int TOTAL_W     = 32;
	localparam int RUN_W       = 8;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (2 * MM_W + 1 + 2 * TOTAL_W);
	localparam int IN_PAD_W    = IN_TDATA_W - (3 + MM_W);

	localparam int MEDIAN_MIN_FILL = 3;
	localparam int FAST_MIN_FILL   = 2;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	localparam logic [CFG_ADDR_W-1:0] CFG_SCALE       = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RANGE   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RANGE   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_FAR         = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_FAST_CLOSE  = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_FAULT_COUNT = 3'd5;

	typedef enum logic [1:0] {
		K_MISS,
		K_FAR,
		K_MEAS
	} kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_FIN
	} bstate_t;

	typedef struct packed {
		logic [MM_W-1:0]  scale;
		logic [MM_W-1:0]  max_range;
		logic [MM_W-1:0]  min_range;
		logic [MM_W-1:0]  far;
		logic [MM_W-1:0]  fast_close;
		logic [RUN_W-1:0] fault_count;
	} cfg_t;

	typedef struct packed {
		logic            miss;
		logic [MM_W-1:0] mm;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic               got;
		logic [MM_W-1:0]    raw;
		logic [MM_W-1:0]    filt;
		logic               ok;
		logic [TOTAL_W-1:0] ping;
		logic [TOTAL_W-1:0] miss;
	} result_t;

endpackage

@@ sv/uef_front.sv @@
// Front end: takes ping outcomes, classifies them and scales the pulse width.
// Depends on uef_pkg; pushes one entry per ping into uef_queue.
module uef_front
	import uef_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  busy,
	input  logic                  rose,
	input  logic                  fell,
	input  logic [MM_W-1:0]       pulse,
	input  qstat_t                qstat,
	output logic                  push,
	output entry_t                push_data
);

	logic                  v_s1;
	kind_t                 kind_s1;
	logic [MM_W-1:0]       mm_s1;
	logic [2*MM_W-1:0]     prod;
	kind_t                 kind;

	assign prod = {{MM_W{1'b0}}, pulse} * {{MM_W{1'b0}}, cfg.scale};

	always_comb begin
		if (busy || (rose && !fell)) begin
			kind = K_FAR;
		end else if (rose && fell) begin
			kind = K_MEAS;
		end else begin
			kind = K_MISS;
		end
	end

	assign push     = v_s1 && !qstat.full;
	assign in_ready = !v_s1 || !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			mm_s1   <= prod[2*MM_W-1:MM_W];
		end
	end

	always_comb begin
		push_data.miss = 1'b0;
		push_data.mm   = cfg.far;
		case (kind_s1)
			K_MISS: begin
				push_data.miss = 1'b1;
				push_data.mm   = '0;
			end
			K_FAR: begin
				push_data.mm = cfg.far;
			end
			K_MEAS: begin
				if (mm_s1 > cfg.max_range) begin
					push_data.mm = cfg.far;
				end else if (mm_s1 < cfg.min_range) begin
					push_data.mm = cfg.min_range;
				end else begin
					push_data.mm = mm_s1;
				end
			end
			default: begin
				push_data.mm = cfg.far;
			end
		endcase
	end

endmodule

@@ sv/uef_queue.sv @@
// Two-entry queue between the front end and the filter back end.
// Depends on uef_pkg for the entry and status types.
module uef_queue
	import uef_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t pop_data,
	output qstat_t qstat
);

	entry_t     mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign pop_data    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push || pop)
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> !pop)
		else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
`endif

endmodule

@@ sv/uef_back.sv @@
// Back end: reading history, median by rank scan, fast close, fault tracking.
// Depends on uef_pkg; pops entries from uef_queue and drives the result register.
module uef_back
	import uef_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  entry_t  q_data,
	input  qstat_t  qstat,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	localparam int IW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);

	bstate_t            state_q;
	bstate_t            state_d;
	logic [MM_W-1:0]    ring_q [WINDOW];
	logic [IW-1:0]      wpos_q;
	logic [FW-1:0]      fill_q;
	logic [IW-1:0]      cnt_q;
	logic [MM_W-1:0]    med_q;
	logic [MM_W-1:0]    closer_q;
	logic [MM_W-1:0]    last_raw_q;
	logic [MM_W-1:0]    last_filt_q;
	logic               ok_q;
	logic [TOTAL_W-1:0] ping_q;
	logic [TOTAL_W-1:0] miss_q;
	logic [RUN_W-1:0]   run_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               slot_free;
	logic               take_miss;
	logic               take_read;
	logic               few;
	logic               hit;
	logic               scan_done;
	logic               emit;
	logic [MM_W-1:0]    cand;
	logic [FW-1:0]      lt_cnt;
	logic [FW-1:0]      le_cnt;
	logic [FW-1:0]      k;
	logic [MM_W-1:0]    filt_new;
	logic [RUN_W-1:0]   run_new;

	assign slot_free = !out_valid_q || out_ready;
	assign few       = fill_q < FW'(MEDIAN_MIN_FILL);
	assign cand      = ring_q[cnt_q];
	assign k         = fill_q >> 1;

	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < WINDOW; j++) begin
			if (FW'(j) < fill_q) begin
				lt_cnt = lt_cnt + FW'(ring_q[j] < cand);
				le_cnt = le_cnt + FW'(ring_q[j] <= cand);
			end
		end
	end

	assign hit = (lt_cnt <= k) && (k < le_cnt);

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty && slot_free && !q_data.miss) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				if (few || hit) begin
					state_d = B_FIN;
				end
			end
			B_FIN: begin
				if (slot_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		scan_done = 1'b0;
		emit      = 1'b0;
		case (state_q)
			B_IDLE:  pop       = !qstat.empty && slot_free;
			B_SCAN:  scan_done = few || hit;
			B_FIN:   emit      = slot_free;
			default: pop       = 1'b0;
		endcase
	end

	assign take_miss = pop && q_data.miss;
	assign take_read = pop && !q_data.miss;

	assign filt_new = ((fill_q >= FW'(FAST_MIN_FILL)) &&
		({1'b0, closer_q} + {1'b0, cfg.fast_close} < {1'b0, med_q})) ? closer_q : med_q;
	assign run_new  = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			wpos_q      <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			last_raw_q  <= '0;
			last_filt_q <= '0;
			ok_q        <= 1'b0;
			ping_q      <= '0;
			miss_q      <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_read) begin
				wpos_q     <= (wpos_q == IW'(WINDOW - 1)) ? '0 : wpos_q + IW'(1);
				fill_q     <= (fill_q == FW'(WINDOW)) ? fill_q : fill_q + FW'(1);
				last_raw_q <= q_data.mm;
				cnt_q      <= '0;
			end else if (state_q == B_SCAN && !scan_done) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (take_miss) begin
				miss_q      <= miss_q + TOTAL_W'(1);
				run_q       <= run_new;
				ok_q        <= (run_new >= cfg.fault_count) ? 1'b0 : ok_q;
				out_valid_q <= 1'b1;
			end else if (emit) begin
				last_filt_q <= filt_new;
				ok_q        <= 1'b1;
				ping_q      <= ping_q + TOTAL_W'(1);
				run_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_read) begin
			ring_q[wpos_q] <= q_data.mm;
			closer_q       <= (q_data.mm > last_raw_q) ? q_data.mm : last_raw_q;
		end
		if (scan_done) begin
			med_q <= few ? cfg.far : cand;
		end
		if (take_miss) begin
			out_q.got  <= 1'b0;
			out_q.raw  <= last_raw_q;
			out_q.filt <= last_filt_q;
			out_q.ok   <= (run_new >= cfg.fault_count) ? 1'b0 : ok_q;
			out_q.ping <= ping_q;
			out_q.miss <= miss_q + TOTAL_W'(1);
		end else if (emit) begin
			out_q.got  <= 1'b1;
			out_q.raw  <= last_raw_q;
			out_q.filt <= filt_new;
			out_q.ok   <= 1'b1;
			out_q.ping <= ping_q + TOTAL_W'(1);
			out_q.miss <= miss_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW))
		else $error("history fill beyond window");
	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= IW'(WINDOW - 1))
		else $error("write position beyond window");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SCAN && !few) |-> (FW'(cnt_q) < fill_q))
		else $error("median scan ran past the stored readings");
	a_miss_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_miss |=> out_valid_q && !out_q.got)
		else $error("miss did not load a result");
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q && out_q.got && state_q == B_IDLE)
		else $error("reading did not load a result");
`endif

endmodule

@@ sv/ultrasonic_echo_median_filter.sv @@
// Ultrasonic echo median filter: turns finished ping outcomes into distances.
//
// Input stream s_*: one transaction per finished ping (trigger busy flag,
// rise and fall flags, pulse width in microseconds). Output stream m_*: one
// transaction per ping carrying the raw and filtered distance, the ok flag
// and both running totals; m_tuser is high when the ping gave a reading.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr:
// 0 scale (Q16 mm/us), 1 max range, 2 min range, 3 far value,
// 4 fast close margin, 5 fault count (low 8 bits). Other indexes are ignored.
// Write only while no ping is in flight.
// A miss goes from the front stage register through the queue into the
// result register; a reading also passes the median scan, which tests
// one stored reading per cycle, and the finish state. The back end pops
// no new entry until it has loaded its result. A two-entry queue sits
// between the scaling front end and the back end, so up to three pings may
// be taken ahead of the output.
// Reset clears the history, counters, ok flag and output valid and loads
// the register defaults. A stalled m_tready holds the result and, once the
// queue fills, drops s_tready.
module ultrasonic_echo_median_filter
	import uef_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// busy_at_trigger, echo_rose, echo_fell, pulse_us[15:0], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// raw_mm, filtered_mm, sensor_ok, ping_count, miss_count, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// got_reading
	output logic                   m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t    cfg_q;
	qstat_t  qstat;
	logic    push;
	entry_t  push_data;
	logic    pop;
	entry_t  pop_data;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale       <= 16'd11240;
			cfg_q.max_range   <= 16'd4000;
			cfg_q.min_range   <= 16'd20;
			cfg_q.far         <= 16'd5000;
			cfg_q.fast_close  <= 16'd300;
			cfg_q.fault_count <= 8'd5;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SCALE:       cfg_q.scale       <= cfg_wdata;
				CFG_MAX_RANGE:   cfg_q.max_range   <= cfg_wdata;
				CFG_MIN_RANGE:   cfg_q.min_range   <= cfg_wdata;
				CFG_FAR:         cfg_q.far         <= cfg_wdata;
				CFG_FAST_CLOSE:  cfg_q.fast_close  <= cfg_wdata;
				CFG_FAULT_COUNT: cfg_q.fault_count <= cfg_wdata[RUN_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	uef_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.busy      (s_tdata[0]),
		.rose      (s_tdata[1]),
		.fell      (s_tdata[2]),
		.pulse     (s_tdata[3+MM_W-1:3]),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	uef_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	uef_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_data    (pop_data),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tuser = res.got;
	assign m_tdata = {{OUT_PAD_W{1'b0}}, res.miss, res.ping, res.ok, res.filt, res.raw};

endmodule

@@ test/tb.sv @@
// Self-checking testbench for ultrasonic_echo_median_filter: random and directed pings in,
// each output transaction compared against an in-bench model of the range and median logic.
// Depends on uef_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb;
	import uef_pkg::*;

	localparam int WINDOW = 5;
	localparam int PHASES = 9;
	localparam int PINGS_PER_PHASE = 120;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic            busy;
		logic            rose;
		logic            fell;
		logic [MM_W-1:0] pulse_us;
	} ping_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	ping_t   ping_q[$];
	result_t range_q[$];
	int      pings_queued = 0;
	int      pings_taken = 0;
	int      mismatches = 0;
	int      src_idle_pct = 0;
	int      snk_idle_pct = 0;
	int      src_gap = 0;
	int      snk_gap = 0;
	logic    ping_taken = 1'b0;

	cfg_t               reg_copy;
	logic [MM_W-1:0]    hist [WINDOW];
	int                 hist_wr = 0;
	int                 hist_fill = 0;
	logic [MM_W-1:0]    last_raw_mm = '0;
	logic [MM_W-1:0]    last_filt_mm = '0;
	logic               ok_now = 1'b0;
	logic [TOTAL_W-1:0] readings = '0;
	logic [TOTAL_W-1:0] misses = '0;
	logic [RUN_W-1:0]   miss_run = '0;

	ultrasonic_echo_median_filter #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void store_reading(input logic [MM_W-1:0] mm);
		logic [MM_W-1:0] sorted [WINDOW];
		logic [MM_W-1:0] filt;
		logic [MM_W-1:0] closer;
		logic [MM_W-1:0] v;
		int a;
		int b;
		closer = (mm > last_raw_mm) ? mm : last_raw_mm;
		hist[hist_wr] = mm;
		hist_wr = (hist_wr + 1) % WINDOW;
		if (hist_fill < WINDOW) hist_fill++;
		last_raw_mm = mm;
		filt = reg_copy.far;
		if (hist_fill >= MEDIAN_MIN_FILL) begin
			for (a = 0; a < hist_fill; a++) begin
				v = hist[a];
				b = a;
				while (b > 0 && sorted[b-1] > v) begin
					sorted[b] = sorted[b-1];
					b--;
				end
				sorted[b] = v;
			end
			filt = sorted[hist_fill / 2];
		end
		if (hist_fill >= FAST_MIN_FILL &&
				{1'b0, closer} + {1'b0, reg_copy.fast_close} < {1'b0, filt})
			filt = closer;
		last_filt_mm = filt;
		ok_now = 1'b1;
		readings++;
		miss_run = '0;
	endfunction

	function automatic result_t range_ping(input logic busy, input logic rose, input logic fell,
			input logic [MM_W-1:0] pulse_us);
		logic [2*MM_W-1:0] product;
		logic [MM_W-1:0]   mm;
		result_t           r;
		product = pulse_us * reg_copy.scale;
		mm = product[2*MM_W-1:MM_W];
		if (busy || (rose && !fell)) begin
			store_reading(reg_copy.far);
		end else if (rose) begin
			if (mm > reg_copy.max_range) mm = reg_copy.far;
			else if (mm < reg_copy.min_range) mm = reg_copy.min_range;
			store_reading(mm);
		end else begin
			misses++;
			if (miss_run != RUN_MAX) miss_run++;
			if (miss_run >= reg_copy.fault_count) ok_now = 1'b0;
		end
		r.got = busy | rose;
		r.raw = last_raw_mm;
		r.filt = last_filt_mm;
		r.ok = ok_now;
		r.ping = readings;
		r.miss = misses;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input result_t want, input result_t seen);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%0t %s: expected got=%0d raw=%0d filt=%0d ok=%0d ping=%0d miss=%0d, ",
				$time, what, want.got, want.raw, want.filt, want.ok, want.ping, want.miss);
			$display("actual got=%0d raw=%0d filt=%0d ok=%0d ping=%0d miss=%0d",
				seen.got, seen.raw, seen.filt, seen.ok, seen.ping, seen.miss);
		end
	endtask

	always @(negedge clk) begin : drive_pings
		ping_t p;
		if (arst_n && (!s_tvalid || ping_taken)) begin
			if (src_gap != 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (ping_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
				src_gap = int'($urandom_range(13));
				s_tvalid <= 1'b0;
			end else begin
				p = ping_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{IN_PAD_W{1'b0}}, p.pulse_us, p.fell, p.rose, p.busy};
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (snk_gap != 0) begin
			snk_gap--;
			m_tready <= 1'b0;
		end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
			snk_gap = int'($urandom_range(13));
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_results
		result_t seen;
		result_t want;
		ping_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			seen.got = m_tuser;
			seen.raw = m_tdata[15:0];
			seen.filt = m_tdata[31:16];
			seen.ok = m_tdata[32];
			seen.ping = m_tdata[64:33];
			seen.miss = m_tdata[96:65];
			if (range_q.size() == 0) begin
				report_mismatch("unexpected transaction", '0, seen);
			end else begin
				want = range_q.pop_front();
				if (seen.got !== want.got || seen.raw !== want.raw || seen.filt !== want.filt ||
						seen.ok !== want.ok || seen.ping !== want.ping || seen.miss !== want.miss)
					report_mismatch("field mismatch", want, seen);
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			range_q.push_back(range_ping(s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[18:3]));
			pings_taken++;
		end
	end

	task automatic queue_ping(input logic busy, input logic rose, input logic fell,
			input logic [MM_W-1:0] us);
		ping_t p;
		p.busy = busy;
		p.rose = rose;
		p.fell = fell;
		p.pulse_us = us;
		ping_q.push_back(p);
		pings_queued++;
	endtask

	task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_SCALE:       reg_copy.scale = value;
			CFG_MAX_RANGE:   reg_copy.max_range = value;
			CFG_MIN_RANGE:   reg_copy.min_range = value;
			CFG_FAR:         reg_copy.far = value;
			CFG_FAST_CLOSE:  reg_copy.fast_close = value;
			CFG_FAULT_COUNT: reg_copy.fault_count = value[RUN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pings_taken != pings_queued || range_q.size() != 0) @(negedge clk);
		repeat (WINDOW + 8) @(negedge clk);
	endtask

	task automatic add_random_pings(input int n);
		int               count;
		int               len;
		int               k;
		int unsigned      r;
		logic [MM_W-1:0]  target;
		logic [MM_W-1:0]  us;
		count = 0;
		target = MM_W'($urandom_range(65535) >> $urandom_range(4));
		while (count < n) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// runs around the fault threshold, sometimes past saturation
				if (r < 2) len = int'(reg_copy.fault_count + $urandom_range(3));
				else len = int'($urandom_range(reg_copy.fault_count + 2, 1));
				for (k = 0; k < len; k++)
					queue_ping(1'b0, 1'b0, 1'($urandom_range(1)), MM_W'($urandom));
				count += len;
			end else begin
				if (r < 16) begin
					queue_ping(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)),
						MM_W'($urandom));
				end else if (r < 22) begin
					queue_ping(1'b0, 1'b1, 1'b0, MM_W'($urandom));
				end else begin
					if ($urandom_range(9) == 0)
						target = MM_W'($urandom_range(65535) >> $urandom_range(4));
					if (r < 34) us = MM_W'($urandom);
					else us = MM_W'(target + $urandom_range(64) - 32'd32);
					queue_ping(1'b0, 1'b1, 1'b1, us);
				end
				count++;
			end
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] sc;
		logic [CFG_DATA_W-1:0] mx;
		logic [CFG_DATA_W-1:0] mn;
		logic [CFG_DATA_W-1:0] fr;
		logic [CFG_DATA_W-1:0] fc;
		logic [CFG_DATA_W-1:0] fl;
		int                    phase;
		reg_copy.scale = 16'd11240;
		reg_copy.max_range = 16'd4000;
		reg_copy.min_range = 16'd20;
		reg_copy.far = 16'd5000;
		reg_copy.fast_close = 16'd300;
		reg_copy.fault_count = 8'd5;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_ping(1'b0, 1'b0, 1'b0, 16'h0000);
		queue_ping(1'b0, 1'b0, 1'b1, 16'hFFFF);
		queue_ping(1'b0, 1'b1, 1'b1, 16'h0000);
		queue_ping(1'b0, 1'b1, 1'b1, 16'hFFFF);
		queue_ping(1'b0, 1'b1, 1'b0, 16'd1234);
		queue_ping(1'b1, 1'b0, 1'b0, 16'h0000);
		queue_ping(1'b1, 1'b1, 1'b1, 16'hFFFF);
		queue_ping(1'b1, 1'b1, 1'b0, 16'hAAAA);
		queue_ping(1'b0, 1'b1, 1'b1, 16'd23323);
		queue_ping(1'b0, 1'b1, 1'b1, 16'd2915);
		queue_ping(1'b0, 1'b1, 1'b1, 16'd2915);
		queue_ping(1'b0, 1'b1, 1'b1, 16'd2900);
		repeat (6) queue_ping(1'b0, 1'b0, 1'b0, 16'h5555);
		queue_ping(1'b0, 1'b1, 1'b1, 16'd5830);
		queue_ping(1'b0, 1'b1, 1'b1, 16'd1);
		queue_ping(1'b1, 1'b0, 1'b1, 16'h0000);
		queue_ping(1'b0, 1'b1, 1'b1, 16'h8000);
		wait_idle();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					sc = 16'd11240; mx = 16'd4000; mn = 16'd20;
					fr = 16'd5000; fc = 16'd300; fl = 16'd5;
				end
				1: begin
					sc = '1; mx = '1; mn = '1; fr = '1; fc = '1; fl = '1;
				end
				2: begin
					sc = '0; mx = '0; mn = '0; fr = '0; fc = '0; fl = 16'hFF01;
				end
				7: begin
					sc = CFG_DATA_W'($urandom);
					mx = CFG_DATA_W'($urandom);
					mn = CFG_DATA_W'($urandom);
					fr = CFG_DATA_W'($urandom);
					fc = CFG_DATA_W'($urandom);
					fl = {8'($urandom), 8'($urandom_range(255, 1))};
				end
				default: begin
					sc = CFG_DATA_W'($urandom_range(14000, 8000));
					mx = CFG_DATA_W'($urandom_range(65535, 500));
					mn = CFG_DATA_W'($urandom_range(200));
					fr = CFG_DATA_W'($urandom);
					fc = CFG_DATA_W'($urandom_range(2000));
					fl = (phase == 4) ? 16'd255 : {8'($urandom), 8'($urandom_range(20, 1))};
				end
			endcase
			set_reg(CFG_SCALE, sc);
			set_reg(CFG_MAX_RANGE, mx);
			set_reg(CFG_MIN_RANGE, mn);
			set_reg(CFG_FAR, fr);
			set_reg(CFG_FAST_CLOSE, fc);
			set_reg(CFG_FAULT_COUNT, fl);
			set_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
			set_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
			if (phase == PHASES - 1) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else begin
				case (phase % 3)
					0: begin src_idle_pct = 25; snk_idle_pct = 25; end
					1: begin src_idle_pct = 0;  snk_idle_pct = 50; end
					default: begin src_idle_pct = 50; snk_idle_pct = 0; end
				endcase
			end
			add_random_pings(PINGS_PER_PHASE);
			wait_idle();
		end

		if (mismatches == 0 && range_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
